// ===== rtl/ffha_pkg.sv =====
// ============================================================================
// ffha_pkg
// Shared types and codes of the first-fit heap allocator.
// ============================================================================
`default_nettype none

package ffha_pkg;

    localparam int REQ_W   = 15;
    localparam int REL_W   = 14;
    localparam int HW_W    = 15;
    localparam int ROUND_W = 16;
    localparam int SPLIT_SLACK = 128;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_REPORT = 2'd2,
        MODE_RESET  = 2'd3
    } t_mode;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOMEM   = 2'd1;
    localparam logic [1:0] STATUS_BADADDR = 2'd2;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_PACK_RD,
        ST_PACK_CHK,
        ST_PACK_END,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_GRANT_WR0,
        ST_GRANT_WR1,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_FWD_RD,
        ST_FWD_CHK,
        ST_MERGE_WR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_REP_RD,
        ST_REP_CHK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] grant_offset;
        logic [14:0] free_total;
        logic [14:0] used_total;
        logic [8:0]  free_count;
        logic [8:0]  used_count;
        logic [14:0] largest_free_size;
        logic [14:0] largest_used_size;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ffha_table.sv =====
// ============================================================================
// ffha_table
// Block table storage: one write port and one registered read port.
// ============================================================================
`default_nettype none

module ffha_table #(
    parameter int DW    = 31,
    parameter int DEPTH = 256,
    parameter int IW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// ============================================================================
// ffha_ctrl
// Sequencer that walks the block table one entry at a time for every allocate, free and report request.
// ============================================================================
`default_nettype none

module ffha_ctrl #(
    parameter int ARENA_WORDS  = 16384,
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_WORDS = 4,
    parameter int AW = $clog2(ARENA_WORDS + 1),
    parameter int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    parameter int DW = 2 * AW + 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [ffha_pkg::REQ_W-1:0]  i_request_words,
    input  wire logic [ffha_pkg::REL_W-1:0]  i_release_offset,
    input  wire logic [ffha_pkg::HW_W-1:0]   i_heap_words,
    input  wire logic                        i_out_free,
    output logic                             o_idle,
    output logic                             o_done,
    output ffha_pkg::t_result                o_res,
    output logic                             o_mem_we,
    output logic [IW-1:0]                    o_mem_waddr,
    output logic [DW-1:0]                    o_mem_wdata,
    output logic [IW-1:0]                    o_mem_raddr,
    input  wire logic [DW-1:0]               i_mem_rdata
);

    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int RW   = ffha_pkg::ROUND_W;
    localparam int CMPW = ((AW > RW) ? AW : RW) + 1;
    localparam int CLW  = (AW > ffha_pkg::HW_W) ? AW : ffha_pkg::HW_W;

    ffha_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_idx, n_idx, r_j, n_j, r_count, n_count, r_rover, n_rover;
    logic [CW-1:0] r_u, n_u, r_first, n_first, r_last, n_last, r_gap, n_gap;
    logic [RW-1:0] r_n, n_n;
    logic [ffha_pkg::REL_W-1:0] r_rel, n_rel;
    logic r_pass, n_pass, r_pend, n_pend, r_split, n_split;
    logic r_cur_used, n_cur_used;
    logic [AW-1:0] r_cur_size, n_cur_size, r_cur_off, n_cur_off;
    logic [AW-1:0] r_first_off, n_first_off, r_last_off, n_last_off;
    logic [AW-1:0] r_last_size, n_last_size, r_lf, n_lf, r_lu, n_lu;
    ffha_pkg::t_result r_res, n_res;

    logic          e_used;
    logic [AW-1:0] e_size, e_off;
    logic [RW-1:0] req_round;
    logic [CLW-1:0] hw_clamp;
    logic [AW-1:0] arena_size;
    logic          fit, do_split;

    assign e_used = i_mem_rdata[DW-1];
    assign e_size = i_mem_rdata[DW-2 -: AW];
    assign e_off  = i_mem_rdata[AW-1:0];

    always_comb begin
        req_round = (RW'(i_request_words) + RW'(7)) & ~RW'(7);
        if (req_round == '0) begin
            req_round = RW'(1);
        end
        hw_clamp = CLW'(i_heap_words);
        if (hw_clamp < CLW'(64)) begin
            hw_clamp = CLW'(64);
        end
        if (hw_clamp > CLW'(ARENA_WORDS)) begin
            hw_clamp = CLW'(ARENA_WORDS);
        end
        hw_clamp   = hw_clamp & ~CLW'(7);
        arena_size = AW'(hw_clamp - CLW'(HEADER_WORDS));
    end

    assign fit      = !e_used && (CMPW'(e_size) >= CMPW'(r_n));
    assign do_split = (CMPW'(e_size) > CMPW'(r_n) + CMPW'(ffha_pkg::SPLIT_SLACK))
                      && (r_count < CW'(MAX_BLOCKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::ST_INIT;
            r_count <= CW'(1);
            r_rover <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rover <= n_rover;
        end
        r_idx <= n_idx;           r_j <= n_j;
        r_u <= n_u;               r_first <= n_first;
        r_last <= n_last;         r_gap <= n_gap;
        r_n <= n_n;               r_rel <= n_rel;
        r_pass <= n_pass;         r_pend <= n_pend;
        r_split <= n_split;       r_cur_used <= n_cur_used;
        r_cur_size <= n_cur_size; r_cur_off <= n_cur_off;
        r_first_off <= n_first_off;
        r_last_off <= n_last_off; r_last_size <= n_last_size;
        r_lf <= n_lf;             r_lu <= n_lu;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;   n_idx = r_idx;     n_j = r_j;
        n_count = r_count;   n_rover = r_rover; n_u = r_u;
        n_first = r_first;   n_last = r_last;   n_gap = r_gap;
        n_n = r_n;           n_rel = r_rel;     n_pass = r_pass;
        n_pend = r_pend;     n_split = r_split;
        n_cur_used = r_cur_used; n_cur_size = r_cur_size; n_cur_off = r_cur_off;
        n_first_off = r_first_off;
        n_last_off = r_last_off; n_last_size = r_last_size;
        n_lf = r_lf;         n_lu = r_lu;       n_res = r_res;
        o_idle = 1'b0;
        o_done = 1'b0;
        o_mem_we = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = r_idx[IW-1:0];

        unique case (r_state)
            ffha_pkg::ST_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = {1'b0, arena_size, AW'(0)};
                n_count     = CW'(1);
                n_rover     = '0;
                n_state     = ffha_pkg::ST_IDLE;
            end
            ffha_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_res  = '0;
                    n_n    = req_round;
                    n_rel  = i_release_offset;
                    n_pass = 1'b0;
                    n_idx  = '0;
                    n_lf   = '0;
                    n_lu   = '0;
                    unique case (ffha_pkg::t_mode'(i_mode))
                        ffha_pkg::MODE_ALLOC: begin
                            n_idx   = (r_rover < r_count) ? r_rover : '0;
                            n_state = ffha_pkg::ST_FIND_RD;
                        end
                        ffha_pkg::MODE_FREE:   n_state = ffha_pkg::ST_FREE_RD;
                        ffha_pkg::MODE_REPORT: n_state = ffha_pkg::ST_REP_RD;
                        ffha_pkg::MODE_RESET: begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {1'b0, arena_size, AW'(0)};
                            n_count     = CW'(1);
                            n_rover     = '0;
                            n_state     = ffha_pkg::ST_FIN;
                        end
                        default: n_state = ffha_pkg::ST_FIN;
                    endcase
                end
            end
            ffha_pkg::ST_FIND_RD: begin
                if (r_idx >= r_count) begin
                    if (r_pass) begin
                        n_res.status = ffha_pkg::STATUS_NOMEM;
                        n_state      = ffha_pkg::ST_FIN;
                    end else begin
                        n_idx   = '0;
                        n_j     = '0;
                        n_pend  = 1'b0;
                        n_state = ffha_pkg::ST_PACK_RD;
                    end
                end else begin
                    n_state = ffha_pkg::ST_FIND_CHK;
                end
            end
            ffha_pkg::ST_FIND_CHK: begin
                if (fit) begin
                    n_cur_size = e_size;
                    n_cur_off  = e_off;
                    n_u        = r_idx;
                    n_split    = do_split;
                    n_idx      = r_count;
                    n_state    = do_split ? ffha_pkg::ST_SPLIT_RD : ffha_pkg::ST_GRANT_WR0;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ffha_pkg::ST_FIND_RD;
                end
            end
            ffha_pkg::ST_PACK_RD: begin
                n_state = (r_idx >= r_count) ? ffha_pkg::ST_PACK_END : ffha_pkg::ST_PACK_CHK;
            end
            ffha_pkg::ST_PACK_CHK: begin
                // A free entry after a pending free entry joins its run.
                if (r_pend && !r_cur_used && !e_used) begin
                    n_cur_size = AW'(e_off - r_cur_off + e_size - AW'(HEADER_WORDS));
                end else begin
                    if (r_pend) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_j[IW-1:0];
                        o_mem_wdata = {r_cur_used, r_cur_size, r_cur_off};
                        n_j         = r_j + CW'(1);
                    end
                    if (!e_used) begin
                        n_rover = r_pend ? r_j + CW'(1) : r_j;
                    end
                    n_pend     = 1'b1;
                    n_cur_used = e_used;
                    n_cur_size = e_size;
                    n_cur_off  = e_off;
                end
                n_idx   = r_idx + CW'(1);
                n_state = ffha_pkg::ST_PACK_RD;
            end
            ffha_pkg::ST_PACK_END: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j[IW-1:0];
                o_mem_wdata = {r_cur_used, r_cur_size, r_cur_off};
                n_count     = r_j + CW'(1);
                n_pass      = 1'b1;
                n_idx       = '0;
                n_state     = ffha_pkg::ST_FIND_RD;
            end
            ffha_pkg::ST_SPLIT_RD: begin
                // Open a slot after the found entry by moving the tail up by one.
                o_mem_raddr = IW'(r_idx - CW'(1));
                n_state = (r_idx > r_u + CW'(1)) ? ffha_pkg::ST_SPLIT_WR
                                                  : ffha_pkg::ST_GRANT_WR0;
            end
            ffha_pkg::ST_SPLIT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx[IW-1:0];
                o_mem_wdata = i_mem_rdata;
                n_idx       = r_idx - CW'(1);
                n_state     = ffha_pkg::ST_SPLIT_RD;
            end
            ffha_pkg::ST_GRANT_WR0: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_u[IW-1:0];
                o_mem_wdata = {1'b1, r_split ? AW'(r_n) : r_cur_size, r_cur_off};
                n_rover     = r_u + CW'(1);
                n_res.status = ffha_pkg::STATUS_OK;
                n_res.grant_offset = 14'(CMPW'(r_cur_off) + CMPW'(HEADER_WORDS));
                n_state = r_split ? ffha_pkg::ST_GRANT_WR1 : ffha_pkg::ST_FIN;
            end
            ffha_pkg::ST_GRANT_WR1: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = IW'(r_u + CW'(1));
                o_mem_wdata = {1'b0, AW'(r_cur_size - AW'(r_n) - AW'(HEADER_WORDS)),
                               AW'(r_cur_off + AW'(HEADER_WORDS) + AW'(r_n))};
                n_count     = r_count + CW'(1);
                n_state     = ffha_pkg::ST_FIN;
            end
            ffha_pkg::ST_FREE_RD: begin
                if (r_idx >= r_count) begin
                    n_res.status = ffha_pkg::STATUS_BADADDR;
                    n_state      = ffha_pkg::ST_FIN;
                end else begin
                    n_state = ffha_pkg::ST_FREE_CHK;
                end
            end
            ffha_pkg::ST_FREE_CHK: begin
                if (CMPW'(e_off) + CMPW'(HEADER_WORDS) == CMPW'(r_rel)) begin
                    n_cur_size  = e_size;
                    n_cur_off   = e_off;
                    n_u         = r_idx;
                    n_first     = r_idx;
                    n_first_off = e_off;
                    n_last      = r_idx;
                    n_last_off  = e_off;
                    n_last_size = e_size;
                    n_state     = ffha_pkg::ST_BACK_RD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ffha_pkg::ST_FREE_RD;
                end
            end
            ffha_pkg::ST_BACK_RD: begin
                o_mem_raddr = IW'(r_first - CW'(1));
                n_state = (r_first == '0) ? ffha_pkg::ST_FWD_RD : ffha_pkg::ST_BACK_CHK;
            end
            ffha_pkg::ST_BACK_CHK: begin
                if (!e_used) begin
                    n_first     = r_first - CW'(1);
                    n_first_off = e_off;
                    n_state     = ffha_pkg::ST_BACK_RD;
                end else begin
                    n_state = ffha_pkg::ST_FWD_RD;
                end
            end
            ffha_pkg::ST_FWD_RD: begin
                o_mem_raddr = IW'(r_last + CW'(1));
                n_state = (r_last + CW'(1) >= r_count) ? ffha_pkg::ST_MERGE_WR
                                                        : ffha_pkg::ST_FWD_CHK;
            end
            ffha_pkg::ST_FWD_CHK: begin
                if (!e_used) begin
                    n_last      = r_last + CW'(1);
                    n_last_off  = e_off;
                    n_last_size = e_size;
                    n_state     = ffha_pkg::ST_FWD_RD;
                end else begin
                    n_state = ffha_pkg::ST_MERGE_WR;
                end
            end
            ffha_pkg::ST_MERGE_WR: begin
                o_mem_we     = 1'b1;
                n_rover      = r_first;
                n_res.status = ffha_pkg::STATUS_OK;
                if (r_last == r_first) begin
                    o_mem_waddr = r_u[IW-1:0];
                    o_mem_wdata = {1'b0, r_cur_size, r_cur_off};
                    n_state     = ffha_pkg::ST_FIN;
                end else begin
                    o_mem_waddr = r_first[IW-1:0];
                    o_mem_wdata = {1'b0, AW'(r_last_off - r_first_off + r_last_size
                                              - AW'(HEADER_WORDS)), r_first_off};
                    n_gap   = r_last - r_first;
                    n_idx   = r_last + CW'(1);
                    n_state = ffha_pkg::ST_SHIFT_RD;
                end
            end
            ffha_pkg::ST_SHIFT_RD: begin
                if (r_idx >= r_count) begin
                    n_count = r_count - r_gap;
                    n_state = ffha_pkg::ST_FIN;
                end else begin
                    n_state = ffha_pkg::ST_SHIFT_WR;
                end
            end
            ffha_pkg::ST_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = IW'(r_idx - r_gap);
                o_mem_wdata = i_mem_rdata;
                n_idx       = r_idx + CW'(1);
                n_state     = ffha_pkg::ST_SHIFT_RD;
            end
            ffha_pkg::ST_REP_RD: begin
                n_state = (r_idx >= r_count) ? ffha_pkg::ST_FIN : ffha_pkg::ST_REP_CHK;
            end
            ffha_pkg::ST_REP_CHK: begin
                if (e_used) begin
                    n_res.used_total = r_res.used_total + 15'(e_size);
                    n_res.used_count = r_res.used_count + 9'd1;
                    if (e_size > r_lu) begin
                        n_lu = e_size;
                        n_res.largest_used_size = 15'(e_size);
                    end
                end else begin
                    n_res.free_total = r_res.free_total + 15'(e_size);
                    n_res.free_count = r_res.free_count + 9'd1;
                    if (e_size > r_lf) begin
                        n_lf = e_size;
                        n_res.largest_free_size = 15'(e_size);
                    end
                end
                n_idx   = r_idx + CW'(1);
                n_state = ffha_pkg::ST_REP_RD;
            end
            ffha_pkg::ST_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ffha_pkg::ST_IDLE;
                end
            end
            default: n_state = ffha_pkg::ST_IDLE;
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// Sequence: allocate visits table entries, with up to two searches, one
//   merging pass and one tail shift; free searches, merges and shifts the tail;
// report walks every block; arena reset rewrites the initial free block.
// Throughput: one request at a time, bound by the single read port of the table.
// Reset: synchronous; the first state after reset writes the initial free block.
// ============================================================================
// first_fit_heap_allocator
// First-fit heap allocator, searching from a roving index, with free-run merging over an ordered block table.
// ============================================================================
`default_nettype none

module first_fit_heap_allocator #(
    parameter int ARENA_WORDS  = 16384,
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_WORDS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [14:0] i_request_words,
    input  wire logic [13:0] i_release_offset,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [13:0]      o_grant_offset,
    output logic [14:0]      o_free_total,
    output logic [14:0]      o_used_total,
    output logic [8:0]       o_free_count,
    output logic [8:0]       o_used_count,
    output logic [14:0]      o_largest_free_size,
    output logic [14:0]      o_largest_used_size,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [14:0] i_cfg_heap_words
);

    localparam int AW = $clog2(ARENA_WORDS + 1);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int DW = 2 * AW + 1;

    logic [14:0]       r_heap_words;
    logic              r_out_valid;
    ffha_pkg::t_result r_out;
    ffha_pkg::t_result ctrl_res;
    logic              ctrl_idle, ctrl_done, out_free;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    logic [DW-1:0]     mem_wdata, mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ctrl_idle;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_words <= 15'd16384;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_heap_words <= i_cfg_heap_words;
            end
            if (ctrl_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (ctrl_done) begin
            r_out <= ctrl_res;
        end
    end

    ffha_ctrl #(
        .ARENA_WORDS  (ARENA_WORDS),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_WORDS (HEADER_WORDS),
        .AW           (AW),
        .IW           (IW),
        .DW           (DW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_in_valid && ctrl_idle),
        .i_mode           (i_mode),
        .i_request_words  (i_request_words),
        .i_release_offset (i_release_offset),
        .i_heap_words     (r_heap_words),
        .i_out_free       (out_free),
        .o_idle           (ctrl_idle),
        .o_done           (ctrl_done),
        .o_res            (ctrl_res),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata      (mem_wdata),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata)
    );

    ffha_table #(
        .DW    (DW),
        .DEPTH (MAX_BLOCKS),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out.status;
    assign o_grant_offset      = r_out.grant_offset;
    assign o_free_total        = r_out.free_total;
    assign o_used_total        = r_out.used_total;
    assign o_free_count        = r_out.free_count;
    assign o_used_count        = r_out.used_count;
    assign o_largest_free_size = r_out.largest_free_size;
    assign o_largest_used_size = r_out.largest_used_size;

    // An accepted request leaves the sequencer busy in the cycle after the transfer.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("sequencer ready straight after a transfer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_bad_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ffha_pkg::STATUS_BADADDR |->
        o_grant_offset == '0 && o_free_count == '0 && o_used_count == '0)
        else $error("failed free carries result data");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ============================================================================
// First-fit heap allocator testbench
// Drives allocate, free, report and arena-reset requests through the valid and
// ready channels, predicts every result from a behavioural copy of the block
// table and compares each result field by field.
// ============================================================================
`timescale 1ns / 1ps

class heap_scoreboard;
    int unsigned blk_offset[256];
    int unsigned blk_words[256];
    bit          blk_busy[256];
    int unsigned n_blocks;
    int unsigned rover;
    int unsigned heap_reg;
    ffha_pkg::t_result pending[$];
    int          errors;
    int          checked;
    int          grants;

    function new();
        heap_reg = 16384;
        errors   = 0;
        checked  = 0;
        grants   = 0;
        rebuild();
    endfunction

    function void rebuild();
        int unsigned hw;
        hw = heap_reg;
        if (hw < 64) hw = 64;
        if (hw > 16384) hw = 16384;
        hw = hw & ~32'd7;
        n_blocks     = 1;
        blk_offset[0] = 0;
        blk_words[0]  = hw - 4;
        blk_busy[0]   = 0;
        rover         = 0;
    endfunction

    function void merge_span(int unsigned lo, int unsigned hi);
        int unsigned gap;
        if (hi <= lo || hi >= n_blocks) return;
        blk_words[lo] = blk_offset[hi] - blk_offset[lo] + blk_words[hi] - 4;
        gap = hi - lo;
        for (int unsigned k = hi + 1; k < n_blocks; k++) begin
            blk_offset[k - gap] = blk_offset[k];
            blk_words[k - gap]  = blk_words[k];
            blk_busy[k - gap]   = blk_busy[k];
        end
        n_blocks -= gap;
    endfunction

    function void coalesce_all();
        int unsigned i, j;
        i = 0;
        while (i < n_blocks) begin
            if (!blk_busy[i]) begin
                j = i;
                while (j + 1 < n_blocks && !blk_busy[j + 1]) j++;
                merge_span(i, j);
                rover = i;
            end
            i++;
        end
    endfunction

    function bit first_fit(int unsigned from, int unsigned need, output int unsigned at);
        at = 0;
        for (int unsigned i = from; i < n_blocks; i++) begin
            if (!blk_busy[i] && blk_words[i] >= need) begin
                at = i;
                return 1;
            end
        end
        return 0;
    endfunction

    function void allocate(int unsigned req, ref ffha_pkg::t_result r);
        int unsigned need, from, u, orig;
        need = (req + 7) & ~32'd7;
        if (need == 0) need = 1;
        from = (rover < n_blocks) ? rover : 0;
        if (!first_fit(from, need, u)) begin
            coalesce_all();
            if (!first_fit(0, need, u)) begin
                r.status = ffha_pkg::STATUS_NOMEM;
                return;
            end
        end
        blk_busy[u] = 1;
        orig = blk_words[u];
        if (orig > need + ffha_pkg::SPLIT_SLACK && n_blocks < 256) begin
            for (int unsigned k = n_blocks; k > u + 1; k--) begin
                blk_offset[k] = blk_offset[k - 1];
                blk_words[k]  = blk_words[k - 1];
                blk_busy[k]   = blk_busy[k - 1];
            end
            n_blocks++;
            blk_words[u]      = need;
            blk_offset[u + 1] = blk_offset[u] + 4 + need;
            blk_words[u + 1]  = orig - need - 4;
            blk_busy[u + 1]   = 0;
        end
        rover = u + 1;
        r.grant_offset = 14'(blk_offset[u] + 4);
        grants++;
    endfunction

    function void release_block(int unsigned addr, ref ffha_pkg::t_result r);
        int unsigned i, first, last;
        for (i = 0; i < n_blocks; i++)
            if (blk_offset[i] + 4 == addr) break;
        if (i >= n_blocks) begin
            r.status = ffha_pkg::STATUS_BADADDR;
            return;
        end
        blk_busy[i] = 0;
        first = i;
        while (first > 0 && !blk_busy[first - 1]) first--;
        last = i;
        while (last + 1 < n_blocks && !blk_busy[last + 1]) last++;
        rover = first;
        merge_span(first, last);
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(ffha_pkg::t_mode mode, int unsigned req, int unsigned rel);
        ffha_pkg::t_result r;
        int unsigned ft, ut, fc, uc, lf, lu;
        r = '0;
        ft = 0; ut = 0; fc = 0; uc = 0; lf = 0; lu = 0;
        case (mode)
            ffha_pkg::MODE_ALLOC: allocate(req, r);
            ffha_pkg::MODE_FREE: release_block(rel, r);
            ffha_pkg::MODE_REPORT: begin
                for (int unsigned i = 0; i < n_blocks; i++) begin
                    if (blk_busy[i]) begin
                        ut += blk_words[i]; uc++;
                        if (blk_words[i] > lu) lu = blk_words[i];
                    end else begin
                        ft += blk_words[i]; fc++;
                        if (blk_words[i] > lf) lf = blk_words[i];
                    end
                end
                r.free_total        = 15'(ft);
                r.used_total        = 15'(ut);
                r.free_count        = 9'(fc);
                r.used_count        = 9'(uc);
                r.largest_free_size = 15'(lf);
                r.largest_used_size = 15'(lu);
            end
            default: rebuild();
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(ffha_pkg::t_result got);
        ffha_pkg::t_result exp_r;
        if (pending.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        if (got.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, got.status); errors++;
        end
        if (got.grant_offset !== exp_r.grant_offset) begin
            $error("grant_offset expected %0d actual %0d", exp_r.grant_offset,
                   got.grant_offset); errors++;
        end
        if (got.free_total !== exp_r.free_total) begin
            $error("free_total expected %0d actual %0d", exp_r.free_total,
                   got.free_total); errors++;
        end
        if (got.used_total !== exp_r.used_total) begin
            $error("used_total expected %0d actual %0d", exp_r.used_total,
                   got.used_total); errors++;
        end
        if (got.free_count !== exp_r.free_count) begin
            $error("free_count expected %0d actual %0d", exp_r.free_count,
                   got.free_count); errors++;
        end
        if (got.used_count !== exp_r.used_count) begin
            $error("used_count expected %0d actual %0d", exp_r.used_count,
                   got.used_count); errors++;
        end
        if (got.largest_free_size !== exp_r.largest_free_size) begin
            $error("largest_free_size expected %0d actual %0d", exp_r.largest_free_size,
                   got.largest_free_size); errors++;
        end
        if (got.largest_used_size !== exp_r.largest_used_size) begin
            $error("largest_used_size expected %0d actual %0d", exp_r.largest_used_size,
                   got.largest_used_size); errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_CYCLES = 40000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_mode = ffha_pkg::MODE_REPORT;
    logic [14:0] i_request_words = '0;
    logic [13:0] i_release_offset = '0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [1:0]  o_status;
    logic [13:0] o_grant_offset;
    logic [14:0] o_free_total, o_used_total, o_largest_free_size, o_largest_used_size;
    logic [8:0]  o_free_count, o_used_count;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_heap_words = '0;

    heap_scoreboard board;
    int unsigned    live_grants[$];
    bit             calm = 0;
    bit             hold_off = 0;
    int             idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    first_fit_heap_allocator DUT (.*);

    // Result side: random stalls, with a calm stretch and one long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result('{o_status, o_grant_offset, o_free_total, o_used_total,
                                 o_free_count, o_used_count, o_largest_free_size,
                                 o_largest_used_size});
        i_out_ready <= !hold_off && (calm || $urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(ffha_pkg::t_mode mode, int unsigned req, int unsigned rel);
        while (!calm && $urandom_range(99) < 21) @(posedge i_clk);
        i_in_valid       <= 1;
        i_mode           <= mode;
        i_request_words  <= 15'(req);
        i_release_offset <= 14'(rel);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(mode, req, rel);
        if (mode == ffha_pkg::MODE_ALLOC && board.pending[$].status == ffha_pkg::STATUS_OK)
            live_grants.push_back(board.pending[$].grant_offset);
        if (mode == ffha_pkg::MODE_RESET) live_grants.delete();
        i_in_valid <= 0;
        // The block is busy after a transfer, so this cycle costs nothing.
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Registers change only with the block idle; the new size applies at arena reset.
    task automatic write_heap_words(int unsigned value);
        drain();
        i_cfg_valid      <= 1;
        i_cfg_heap_words <= 15'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.heap_reg = value & 32'h7fff;
        i_cfg_valid <= 0;
        send(ffha_pkg::MODE_RESET, 0, 0);
    endtask

    task automatic random_item();
        int unsigned pick, idx, rel;
        pick = $urandom_range(99);
        if (pick < 45) begin
            // Mostly small requests, now and then a very large one.
            if ($urandom_range(19) == 0) send(ffha_pkg::MODE_ALLOC, 0, $urandom);
            else if ($urandom_range(29) == 0)
                send(ffha_pkg::MODE_ALLOC, $urandom_range(32767), 0);
            else send(ffha_pkg::MODE_ALLOC, $urandom_range(300), $urandom);
        end else if (pick < 85) begin
            if (live_grants.size() != 0 && $urandom_range(9) != 0) begin
                idx = $urandom_range(live_grants.size() - 1);
                rel = live_grants[idx];
                live_grants.delete(idx);
            end else begin
                rel = $urandom_range(16383);
            end
            send(ffha_pkg::MODE_FREE, $urandom, rel);
        end else if (pick < 98) begin
            send(ffha_pkg::MODE_REPORT, $urandom, $urandom);
        end else begin
            send(ffha_pkg::MODE_RESET, $urandom, $urandom);
        end
    endtask

    initial begin
        int unsigned sizes[4];
        board = new();
        sizes = '{64, 16384, 1000, 32767};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, every request kind, bad and repeated frees, full arena.
        send(ffha_pkg::MODE_REPORT, 0, 0);
        send(ffha_pkg::MODE_ALLOC, 0, 0);
        send(ffha_pkg::MODE_ALLOC, 1, 0);
        send(ffha_pkg::MODE_ALLOC, 32767, 16383);
        send(ffha_pkg::MODE_ALLOC, 16380, 0);
        send(ffha_pkg::MODE_FREE, 0, 16383);
        send(ffha_pkg::MODE_FREE, 0, 4);
        send(ffha_pkg::MODE_FREE, 0, 4);
        send(ffha_pkg::MODE_ALLOC, 200, 0);
        send(ffha_pkg::MODE_ALLOC, 16000, 0);
        send(ffha_pkg::MODE_REPORT, 32767, 16383);
        send(ffha_pkg::MODE_FREE, 0, 5);
        send(ffha_pkg::MODE_RESET, 0, 0);
        send(ffha_pkg::MODE_ALLOC, 16380, 0);
        send(ffha_pkg::MODE_ALLOC, 8, 0);
        send(ffha_pkg::MODE_REPORT, 0, 0);
        // Allocate eight small blocks of growing size.
        for (int i = 0; i < 8; i++) send(ffha_pkg::MODE_ALLOC, 16 + 8 * i, 0);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 4) write_heap_words(sizes[phase]);
            else write_heap_words($urandom_range(64, 16384));
            calm = (phase == 2);
            if (phase == 3) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 145; n++) random_item();
            // Pack the table towards its limit with many small allocations.
            if (phase == 1)
                for (int n = 0; n < 270; n++)
                    send(ffha_pkg::MODE_ALLOC, $urandom_range(8), 0);
            send(ffha_pkg::MODE_REPORT, 0, 0);
        end
        calm = 0;
        drain();
        $display("Covered %0d results, %0d successful grants, six arena sizes.",
                 board.checked, board.grants);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_table.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
verif/tb_top.sv
